// ----- rtl/ctiu_pkg.sv -----
`default_nettype none
package ctiu_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [9:0] A_PEND_LO_SET = 10'h040;
  localparam logic [9:0] A_PEND_LO_CLR = 10'h044;
  localparam logic [9:0] A_MASK_LO_SET = 10'h048;
  localparam logic [9:0] A_MASK_LO_CLR = 10'h04C;
  localparam logic [9:0] A_PEND_HI_SET = 10'h060;
  localparam logic [9:0] A_PEND_HI_CLR = 10'h064;
  localparam logic [9:0] A_MASK_HI_SET = 10'h068;
  localparam logic [9:0] A_MASK_HI_CLR = 10'h06C;
  localparam logic [9:0] A_CTL0_SET    = 10'h200;
  localparam logic [9:0] A_CTL0_CLR    = 10'h204;
  localparam logic [9:0] A_CTL1_SET    = 10'h208;
  localparam logic [9:0] A_CTL1_CLR    = 10'h20C;
  localparam logic [9:0] A_TICK_DELAY  = 10'h220;

  // Timer slots sit at 0x100 + 8*t; this is addr[9:7] for that window.
  localparam logic [2:0] A_TIMER_WIN   = 3'b010;

  localparam int CTL_DEC     = 0;
  localparam int CTL_RELOAD  = 1;
  localparam int CTL_CASCADE = 2;

  localparam logic [31:0] BIT31           = 32'h8000_0000;
  localparam logic [9:0]  TICK_DELAY_INIT = 10'd64;
  localparam logic [3:0]  IRQ_TOP_BIT     = 4'd10;

  typedef struct packed {
    logic bus_write;
    logic bus_read;
    logic result_load;
    logic tick_step;
    logic tick_first;
  } ctiu_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/ctiu_datapath.sv -----
`default_nettype none
module ctiu_datapath #(
  parameter int NUM_TIMERS = 16,
  parameter int IW = $clog2(NUM_TIMERS)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctiu_pkg::ctiu_cmd_t cmd_in,
  input  wire logic [IW-1:0]      idx,
  input  wire logic [9:0]         addr,
  input  wire logic [31:0]        write_data,
  output logic [31:0]             read_data,
  output logic                    fiq_request
);

  logic [31:0]      pending_low, pending_high, enable_low, enable_high;
  logic [1:0][31:0] timer_control;
  logic [15:0]      timer_count  [NUM_TIMERS];
  logic [15:0]      timer_reload [NUM_TIMERS];
  logic [9:0]       tick_delay;
  logic             carry;

  logic [31:0]      pending_low_next, pending_high_next, enable_low_next, enable_high_next;
  logic [1:0][31:0] timer_control_next;
  logic [9:0]       tick_delay_next;
  logic             carry_next;

  logic             slot_hit;
  logic [IW-1:0]    tix_sel;
  logic [15:0]      count_rd, reload_rd;
  logic             count_we, reload_we;
  logic [15:0]      count_wd;
  logic [31:0]      rd_val;

  logic [3:0]       tix;
  logic [3:0]       nib;
  logic             carry_in, counting, under;
  logic [3:0]       irq_bit;

  assign slot_hit = (addr[9:7] == ctiu_pkg::A_TIMER_WIN) && (addr[1:0] == 2'b00) &&
                    ({1'b0, addr[6:3]} < 5'(NUM_TIMERS));

  // The tick walker and the bus share one port into the timer registers.
  assign tix_sel   = cmd_in.tick_step ? idx : addr[3 +: IW];
  assign count_rd  = timer_count[tix_sel];
  assign reload_rd = timer_reload[tix_sel];

  assign tix      = 4'(idx);
  assign nib      = timer_control[tix[3]][{tix[2:0], 2'b00} +: 4];
  assign carry_in = !nib[ctiu_pkg::CTL_CASCADE] || cmd_in.tick_first || carry;
  assign counting = carry_in && nib[ctiu_pkg::CTL_DEC];
  assign under    = counting && (count_rd == 16'h0000);
  assign irq_bit  = ctiu_pkg::IRQ_TOP_BIT - {1'b0, tix[3:1]};

  always_comb begin
    pending_low_next   = pending_low;
    pending_high_next  = pending_high;
    enable_low_next    = enable_low;
    enable_high_next   = enable_high;
    timer_control_next = timer_control;
    tick_delay_next    = tick_delay;
    carry_next         = carry;
    count_we           = 1'b0;
    reload_we          = 1'b0;
    count_wd           = write_data[15:0];

    if (cmd_in.bus_write) begin
      case (addr)
        ctiu_pkg::A_PEND_LO_SET: begin
          pending_low_next = pending_low | write_data;
          if (pending_high != 32'd0) pending_low_next[31] = 1'b1;
        end
        ctiu_pkg::A_PEND_LO_CLR: begin
          pending_low_next = pending_low & ~write_data;
          if (pending_high == 32'd0) pending_low_next[31] = 1'b0;
        end
        ctiu_pkg::A_PEND_HI_SET: begin
          pending_high_next = pending_high | write_data;
          if (pending_high_next != 32'd0) pending_low_next[31] = 1'b1;
        end
        ctiu_pkg::A_PEND_HI_CLR: begin
          pending_high_next = pending_high & ~write_data;
          if (pending_high_next == 32'd0) pending_low_next[31] = 1'b0;
        end
        ctiu_pkg::A_MASK_LO_SET: enable_low_next = enable_low | write_data;
        ctiu_pkg::A_MASK_LO_CLR: enable_low_next = (enable_low & ~write_data) | ctiu_pkg::BIT31;
        ctiu_pkg::A_MASK_HI_SET: enable_high_next = enable_high | write_data;
        ctiu_pkg::A_MASK_HI_CLR: enable_high_next = enable_high & ~write_data;
        ctiu_pkg::A_CTL0_SET: timer_control_next[0] = timer_control[0] | write_data;
        ctiu_pkg::A_CTL0_CLR: timer_control_next[0] = timer_control[0] & ~write_data;
        ctiu_pkg::A_CTL1_SET: timer_control_next[1] = timer_control[1] | write_data;
        ctiu_pkg::A_CTL1_CLR: timer_control_next[1] = timer_control[1] & ~write_data;
        ctiu_pkg::A_TICK_DELAY: tick_delay_next = write_data[9:0];
        default: begin
          if (slot_hit) begin
            count_we  = !addr[2];
            reload_we = addr[2];
          end
        end
      endcase
    end

    if (cmd_in.tick_step) begin
      carry_next = under;
      if (counting) begin
        count_we = 1'b1;
        count_wd = count_rd - 16'd1;
      end
      if (under) begin
        if (tix[0]) begin
          pending_low_next[irq_bit] = 1'b1;
          if (pending_high != 32'd0) pending_low_next[31] = 1'b1;
        end
        if (nib[ctiu_pkg::CTL_RELOAD]) begin
          count_wd = reload_rd;
        end else begin
          timer_control_next[tix[3]][{tix[2:0], 2'b00} + ctiu_pkg::CTL_DEC] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    case (addr)
      ctiu_pkg::A_PEND_LO_SET, ctiu_pkg::A_PEND_LO_CLR: rd_val = pending_low;
      ctiu_pkg::A_MASK_LO_SET, ctiu_pkg::A_MASK_LO_CLR: rd_val = enable_low | ctiu_pkg::BIT31;
      ctiu_pkg::A_PEND_HI_SET, ctiu_pkg::A_PEND_HI_CLR: rd_val = pending_high;
      ctiu_pkg::A_MASK_HI_SET, ctiu_pkg::A_MASK_HI_CLR: rd_val = enable_high;
      ctiu_pkg::A_CTL0_SET, ctiu_pkg::A_CTL0_CLR: rd_val = timer_control[0];
      ctiu_pkg::A_CTL1_SET, ctiu_pkg::A_CTL1_CLR: rd_val = timer_control[1];
      ctiu_pkg::A_TICK_DELAY: rd_val = {22'd0, tick_delay};
      default: rd_val = slot_hit ? {16'd0, (addr[2] ? reload_rd : count_rd)} : 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_low   <= 32'd0;
      pending_high  <= 32'd0;
      enable_low    <= 32'd0;
      enable_high   <= 32'd0;
      timer_control <= '0;
      tick_delay    <= ctiu_pkg::TICK_DELAY_INIT;
      carry         <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        timer_count[i]  <= 16'd0;
        timer_reload[i] <= 16'd0;
      end
    end else begin
      pending_low   <= pending_low_next;
      pending_high  <= pending_high_next;
      enable_low    <= enable_low_next;
      enable_high   <= enable_high_next;
      timer_control <= timer_control_next;
      tick_delay    <= tick_delay_next;
      carry         <= carry_next;
      if (count_we)  timer_count[tix_sel]  <= count_wd;
      if (reload_we) timer_reload[tix_sel] <= write_data[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_in.result_load) begin
      read_data <= cmd_in.bus_read ? rd_val : 32'd0;
    end
  end

  assign fiq_request = ((pending_low & enable_low) != 32'd0) ||
                       ((pending_high & enable_high) != 32'd0);

endmodule
`default_nettype wire

// ----- rtl/ctiu_ctrl.sv -----
`default_nettype none
module ctiu_ctrl #(
  parameter int NUM_TIMERS = 16,
  parameter int IW = $clog2(NUM_TIMERS)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          cmd,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ctiu_pkg::ctiu_cmd_t      cmd_out,
  output logic [IW-1:0]            idx
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [IW-1:0] idx_next;
  logic          accept;

  assign accept    = in_valid && (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next          = state;
    idx_next            = idx;
    cmd_out             = '0;
    cmd_out.bus_write   = accept && (cmd == ctiu_pkg::CMD_WRITE);
    cmd_out.bus_read    = accept && (cmd == ctiu_pkg::CMD_READ);
    cmd_out.result_load = accept;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          idx_next   = '0;
          state_next = (cmd == ctiu_pkg::CMD_TICK) ? S_TICK : S_OUT;
        end
      end
      S_TICK: begin
        cmd_out.tick_step  = 1'b1;
        cmd_out.tick_first = (idx == '0);
        if (idx == IW'(NUM_TIMERS - 1)) begin
          state_next = S_OUT;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cascaded_timer_interrupt_unit_top.sv -----
`default_nettype none
// Timer and interrupt unit with NUM_TIMERS cascadable 16-bit down-counters and two
// pending/mask pairs driving fiq_request. One word is taken at a time: a bus read or
// write completes in the accept cycle and its result is offered on the next cycle;
// a tick walks the timers one per cycle through a single shared decrement and
// underflow unit before its result is offered. The next word is accepted the cycle
// after the result is taken. fiq_request reflects the interrupt state after the
// word's effect and is valid with read_data.
module cascaded_timer_interrupt_unit_top #(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [9:0]  addr,
  input  wire logic [31:0] write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_data,
  output logic             fiq_request
);

  localparam int IW = $clog2(NUM_TIMERS);

  ctiu_pkg::ctiu_cmd_t cmd_bus;
  logic [IW-1:0]       idx;

  ctiu_ctrl #(.NUM_TIMERS(NUM_TIMERS), .IW(IW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_out   (cmd_bus),
    .idx       (idx)
  );

  ctiu_datapath #(.NUM_TIMERS(NUM_TIMERS), .IW(IW)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd_in      (cmd_bus),
    .idx         (idx),
    .addr        (addr),
    .write_data  (write_data),
    .read_data   (read_data),
    .fiq_request (fiq_request)
  );

endmodule
`default_nettype wire

// ----- rtl/ctiu_checker.sv -----
`default_nettype none
module ctiu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  cmd,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] read_data,
  input wire logic        fiq_request
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(fiq_request))
    else $error("stalled result changed");

  // Only one word is in flight: a pending result keeps the input closed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  // A write gives its zero result on the next cycle.
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == ctiu_pkg::CMD_WRITE |=> out_valid && read_data == 32'd0)
    else $error("write result missing or nonzero");

  // A tick walks the timers before its result is offered.
  a_tick_walks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == ctiu_pkg::CMD_TICK |=> in_stall && !out_valid)
    else $error("tick result too early");

endmodule

bind cascaded_timer_interrupt_unit_top ctiu_checker u_ctiu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .cmd         (cmd),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_data   (read_data),
  .fiq_request (fiq_request)
);
`default_nettype wire

// ----- test/cascaded_timer_interrupt_unit_checker.sv -----
module cascaded_timer_interrupt_unit_checker #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [9:0]  addr,
  input  logic [31:0] write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] read_data,
  input  logic        fiq_request,
  output int          mismatch_count,
  output int          words_awaited
);

  typedef struct packed {
    logic [31:0] read_data;
    logic        fiq;
  } unit_result_t;

  unit_result_t awaited_results[$];
  int mismatches = 0;
  int results_seen = 0;

  logic [31:0] pend_lo, pend_hi, mask_lo, mask_hi;
  logic [31:0] ctl_word [2];
  logic [15:0] count_q [16];
  logic [15:0] reload_q [16];
  logic [9:0]  delay_q;

  initial begin
    mismatch_count = 0;
    words_awaited = 0;
  end

  task automatic reset_unit();
    pend_lo = '0;
    pend_hi = '0;
    mask_lo = '0;
    mask_hi = '0;
    ctl_word[0] = '0;
    ctl_word[1] = '0;
    for (int i = 0; i < 16; i++) begin
      count_q[i] = '0;
      reload_q[i] = '0;
    end
    delay_q = ctiu_pkg::TICK_DELAY_INIT;
  endtask

  // Bit 31 of the low pending word tracks whether the high word holds anything.
  task automatic raise_mirror();
    if (pend_hi != 32'd0) pend_lo = pend_lo | ctiu_pkg::BIT31;
  endtask

  task automatic drop_mirror();
    if (pend_hi == 32'd0) pend_lo = pend_lo & ~ctiu_pkg::BIT31;
  endtask

  task automatic run_tick();
    logic        carry;
    logic [3:0]  flag;
    logic [15:0] c;
    int          w;
    int          sh;
    carry = 1'b1;
    for (int t = 0; t < NUM_TIMERS && t < 16; t++) begin
      w = t >> 3;
      sh = (t & 7) * 4;
      flag = ctl_word[w][sh +: 4];
      // A timer without the cascade bit starts a fresh chain.
      if (!flag[ctiu_pkg::CTL_CASCADE]) carry = 1'b1;
      if (carry && flag[ctiu_pkg::CTL_DEC]) begin
        c = count_q[t];
        carry = (c == 16'd0);
        c = c - 16'd1;
        if (carry) begin
          if ((t % 2) == 1) begin
            pend_lo[int'(ctiu_pkg::IRQ_TOP_BIT) - t / 2] = 1'b1;
            raise_mirror();
          end
          if (flag[ctiu_pkg::CTL_RELOAD]) c = reload_q[t];
          else ctl_word[w][sh + ctiu_pkg::CTL_DEC] = 1'b0;
        end
        count_q[t] = c;
      end else begin
        carry = 1'b0;
      end
    end
  endtask

  task automatic bus_store(input logic [9:0] a, input logic [31:0] v);
    case (a)
      ctiu_pkg::A_PEND_LO_SET: begin
        pend_lo = pend_lo | v;
        raise_mirror();
      end
      ctiu_pkg::A_PEND_LO_CLR: begin
        pend_lo = pend_lo & ~v;
        drop_mirror();
      end
      ctiu_pkg::A_MASK_LO_SET: mask_lo = mask_lo | v;
      ctiu_pkg::A_MASK_LO_CLR: mask_lo = (mask_lo & ~v) | ctiu_pkg::BIT31;
      ctiu_pkg::A_PEND_HI_SET: begin
        pend_hi = pend_hi | v;
        raise_mirror();
      end
      ctiu_pkg::A_PEND_HI_CLR: begin
        pend_hi = pend_hi & ~v;
        drop_mirror();
      end
      ctiu_pkg::A_MASK_HI_SET: mask_hi = mask_hi | v;
      ctiu_pkg::A_MASK_HI_CLR: mask_hi = mask_hi & ~v;
      ctiu_pkg::A_CTL0_SET:    ctl_word[0] = ctl_word[0] | v;
      ctiu_pkg::A_CTL0_CLR:    ctl_word[0] = ctl_word[0] & ~v;
      ctiu_pkg::A_CTL1_SET:    ctl_word[1] = ctl_word[1] | v;
      ctiu_pkg::A_CTL1_CLR:    ctl_word[1] = ctl_word[1] & ~v;
      ctiu_pkg::A_TICK_DELAY:  delay_q = v[9:0];
      default: begin
        if (a[9:7] == ctiu_pkg::A_TIMER_WIN && a[1:0] == 2'b00 &&
            int'(a[6:3]) < NUM_TIMERS) begin
          if (a[2]) reload_q[a[6:3]] = v[15:0];
          else count_q[a[6:3]] = v[15:0];
        end
      end
    endcase
  endtask

  function automatic logic [31:0] bus_fetch(input logic [9:0] a);
    case (a)
      ctiu_pkg::A_PEND_LO_SET, ctiu_pkg::A_PEND_LO_CLR: return pend_lo;
      ctiu_pkg::A_MASK_LO_SET, ctiu_pkg::A_MASK_LO_CLR: return mask_lo | ctiu_pkg::BIT31;
      ctiu_pkg::A_PEND_HI_SET, ctiu_pkg::A_PEND_HI_CLR: return pend_hi;
      ctiu_pkg::A_MASK_HI_SET, ctiu_pkg::A_MASK_HI_CLR: return mask_hi;
      ctiu_pkg::A_CTL0_SET, ctiu_pkg::A_CTL0_CLR:       return ctl_word[0];
      ctiu_pkg::A_CTL1_SET, ctiu_pkg::A_CTL1_CLR:       return ctl_word[1];
      ctiu_pkg::A_TICK_DELAY:                           return {22'd0, delay_q};
      default: begin
        if (a[9:7] == ctiu_pkg::A_TIMER_WIN && a[1:0] == 2'b00 &&
            int'(a[6:3]) < NUM_TIMERS)
          return {16'd0, a[2] ? reload_q[a[6:3]] : count_q[a[6:3]]};
        return 32'd0;
      end
    endcase
  endfunction

  task automatic apply_word(input logic [1:0] c, input logic [9:0] a, input logic [31:0] v,
                            output unit_result_t r);
    r.read_data = 32'd0;
    case (c)
      ctiu_pkg::CMD_WRITE: bus_store(a, v);
      ctiu_pkg::CMD_READ:  r.read_data = bus_fetch(a);
      ctiu_pkg::CMD_TICK:  run_tick();
      default: ;
    endcase
    r.fiq = ((pend_lo & mask_lo) != 32'd0) || ((pend_hi & mask_hi) != 32'd0);
  endtask

  always @(posedge clk) begin
    unit_result_t want;
    if (rst) begin
      reset_unit();
      awaited_results.delete();
    end else begin
      // The result leaving at this edge belongs to an earlier word, so it is
      // matched before the word accepted at the same edge is queued.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing awaited: read_data %h fiq %b",
                     results_seen, read_data, fiq_request);
        end else begin
          want = awaited_results.pop_front();
          if (want.read_data !== read_data || want.fiq !== fiq_request) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: read_data exp %h got %h, fiq exp %b got %b",
                       results_seen, want.read_data, read_data, want.fiq, fiq_request);
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_word(cmd, addr, write_data, want);
        awaited_results.push_back(want);
      end
    end
    mismatch_count <= mismatches;
    words_awaited <= awaited_results.size();
  end

endmodule

// ----- test/cascaded_timer_interrupt_unit_top_test.sv -----
module cascaded_timer_interrupt_unit_top_test;

  localparam int NUM_TIMERS = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [9:0]  addr;
  logic [31:0] write_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        fiq_request;

  int mismatch_count;
  int words_awaited;
  int tx_idle = 10;
  int rx_idle = 77;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cascaded_timer_interrupt_unit_top #(.NUM_TIMERS(NUM_TIMERS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .addr(addr), .write_data(write_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .fiq_request(fiq_request)
  );

  cascaded_timer_interrupt_unit_checker #(.NUM_TIMERS(NUM_TIMERS)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .addr(addr), .write_data(write_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .fiq_request(fiq_request),
    .mismatch_count(mismatch_count), .words_awaited(words_awaited)
  );

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < rx_idle);

  // Values read right after an edge are the ones the block saw at that edge.
  task automatic send_word(input logic [1:0] c, input logic [9:0] a, input logic [31:0] v);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    addr <= a;
    write_data <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_awaited != 0);
  endtask

  function automatic logic [9:0] timer_slot(input int t, input logic reload);
    logic [3:0] idx;
    idx = t[3:0];
    return {ctiu_pkg::A_TIMER_WIN, idx, reload, 2'b00};
  endfunction

  function automatic logic [9:0] pick_register();
    case ($urandom_range(0, 12))
      0:  return ctiu_pkg::A_PEND_LO_SET;
      1:  return ctiu_pkg::A_PEND_LO_CLR;
      2:  return ctiu_pkg::A_MASK_LO_SET;
      3:  return ctiu_pkg::A_MASK_LO_CLR;
      4:  return ctiu_pkg::A_PEND_HI_SET;
      5:  return ctiu_pkg::A_PEND_HI_CLR;
      6:  return ctiu_pkg::A_MASK_HI_SET;
      7:  return ctiu_pkg::A_MASK_HI_CLR;
      8:  return ctiu_pkg::A_CTL0_SET;
      9:  return ctiu_pkg::A_CTL0_CLR;
      10: return ctiu_pkg::A_CTL1_SET;
      11: return ctiu_pkg::A_CTL1_CLR;
      default: return ctiu_pkg::A_TICK_DELAY;
    endcase
  endfunction

  task automatic run_phase(input int tx, input int rx, input int words);
    int          r;
    logic [9:0]  a;
    logic [31:0] v;
    wait_drained();
    tx_idle = tx;
    rx_idle = rx;
    for (int i = 0; i < words; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_word(ctiu_pkg::CMD_TICK, 10'($urandom), $urandom);
      end else if (r < 60) begin
        // Small counts keep underflows and cascades frequent.
        a = timer_slot($urandom_range(0, 15), 1'($urandom_range(0, 1)));
        v = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 5) : $urandom;
        send_word(ctiu_pkg::CMD_WRITE, a, v);
      end else if (r < 75) begin
        a = pick_register();
        // Clears use sparse data so they do not wipe whole words every time.
        if (a[2]) v = $urandom & $urandom & $urandom;
        else v = $urandom & $urandom;
        send_word(ctiu_pkg::CMD_WRITE, a, v);
      end else if (r < 93) begin
        if ($urandom_range(0, 1))
          a = timer_slot($urandom_range(0, 15), 1'($urandom_range(0, 1)));
        else
          a = pick_register();
        send_word(ctiu_pkg::CMD_READ, a, $urandom);
      end else begin
        send_word(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)), $urandom);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= ctiu_pkg::CMD_WRITE;
    addr <= 10'd0;
    write_data <= 32'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_word(ctiu_pkg::CMD_READ, ctiu_pkg::A_TICK_DELAY, 32'd0);
    send_word(ctiu_pkg::CMD_WRITE, ctiu_pkg::A_TICK_DELAY, 32'hFFFF_FFFF);
    send_word(ctiu_pkg::CMD_READ, ctiu_pkg::A_TICK_DELAY, 32'hFFFF_FFFF);
    send_word(ctiu_pkg::CMD_WRITE, ctiu_pkg::A_PEND_HI_SET, 32'h0000_0001);
    send_word(ctiu_pkg::CMD_READ, ctiu_pkg::A_PEND_LO_CLR, 32'd0);
    send_word(ctiu_pkg::CMD_WRITE, ctiu_pkg::A_MASK_LO_CLR, 32'd0);
    send_word(ctiu_pkg::CMD_READ, ctiu_pkg::A_MASK_LO_SET, 32'd0);
    send_word(ctiu_pkg::CMD_WRITE, ctiu_pkg::A_PEND_HI_CLR, 32'hFFFF_FFFF);
    send_word(ctiu_pkg::CMD_WRITE, timer_slot(0, 1'b1), 32'hFFFF_FFFF);
    send_word(ctiu_pkg::CMD_WRITE, ctiu_pkg::A_CTL0_SET, 32'hFFFF_FFFF);
    send_word(ctiu_pkg::CMD_WRITE, ctiu_pkg::A_CTL1_SET, 32'hFFFF_FFFF);
    // Every timer is at zero, so the whole cascade underflows on this tick.
    send_word(ctiu_pkg::CMD_TICK, 10'h3FF, 32'hFFFF_FFFF);
    send_word(ctiu_pkg::CMD_READ, timer_slot(0, 1'b0), 32'd0);
    send_word(ctiu_pkg::CMD_READ, ctiu_pkg::A_PEND_LO_SET, 32'd0);
    send_word(ctiu_pkg::CMD_WRITE, ctiu_pkg::A_CTL0_CLR, 32'h0000_0022);
    send_word(ctiu_pkg::CMD_TICK, 10'd0, 32'd0);
    send_word(ctiu_pkg::CMD_READ, ctiu_pkg::A_CTL0_CLR, 32'd0);
    // Unaligned timer address: the write must be dropped.
    send_word(ctiu_pkg::CMD_WRITE, 10'h102, 32'hFFFF_FFFF);
    send_word(ctiu_pkg::CMD_READ, timer_slot(15, 1'b1), 32'd0);
    send_word(CMD_UNUSED, ctiu_pkg::A_PEND_LO_SET, 32'hFFFF_FFFF);
    send_word(ctiu_pkg::CMD_READ, 10'h3FF, 32'd0);
    send_word(ctiu_pkg::CMD_WRITE, ctiu_pkg::A_MASK_HI_SET, 32'hFFFF_FFFF);
    send_word(ctiu_pkg::CMD_WRITE, ctiu_pkg::A_PEND_HI_SET, ctiu_pkg::BIT31);
    send_word(ctiu_pkg::CMD_WRITE, ctiu_pkg::A_MASK_HI_CLR, 32'hFFFF_FFFF);
    send_word(ctiu_pkg::CMD_READ, ctiu_pkg::A_CTL1_CLR, 32'd0);

    run_phase(10, 77, 620);
    run_phase(77, 10, 620);
    run_phase(0, 0, 620);

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("cascaded_timer_interrupt_unit_top_test: done, clean");
    else
      $display("cascaded_timer_interrupt_unit_top_test: done, errors");
    $finish;
  end

  initial begin
    #800000;
    $display("cascaded_timer_interrupt_unit_top_test: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ctiu_pkg.sv
rtl/ctiu_datapath.sv
rtl/ctiu_ctrl.sv
rtl/cascaded_timer_interrupt_unit_top.sv
rtl/ctiu_checker.sv
test/cascaded_timer_interrupt_unit_checker.sv
test/cascaded_timer_interrupt_unit_top_test.sv
